### src/cvls_pkg.sv
package cvls_pkg;

    // Item kinds on the input side (s_tuser)
    localparam logic [1:0] MODE_LINE_TICK  = 2'd0;
    localparam logic [1:0] MODE_PIXEL_CELL = 2'd1;
    localparam logic [1:0] MODE_FONT_WRITE = 2'd2;

    // Result kinds (m_tuser)
    localparam logic KIND_LINE_REPORT = 1'b0;
    localparam logic KIND_PIXEL_BYTES = 1'b1;

    // Line classes
    localparam logic [1:0] LINE_VSYNC  = 2'd0;
    localparam logic [1:0] LINE_BLANK  = 2'd1;
    localparam logic [1:0] LINE_ACTIVE = 2'd2;

    // Configuration register indexes
    localparam int          CFG_INDEX_W            = 3;
    localparam int          CFG_DATA_W             = 7;
    localparam logic [2:0]  CFG_PAL_STANDARD       = 3'd0;
    localparam logic [2:0]  CFG_GRAPHICS_ENABLE    = 3'd1;
    localparam logic [2:0]  CFG_CHARSET_SELECT     = 3'd2;
    localparam logic [2:0]  CFG_CURSOR_ENABLE      = 3'd3;
    localparam logic [2:0]  CFG_CURSOR_BLINK       = 3'd4;
    localparam logic [2:0]  CFG_CURSOR_COLUMN      = 3'd5;
    localparam logic [2:0]  CFG_CURSOR_ROW         = 3'd6;

    // Frame geometry
    localparam logic [8:0] PAL_LAST_LINE      = 9'd312;
    localparam logic [8:0] NTSC_LAST_LINE     = 9'd262;
    localparam logic [8:0] PAL_VSYNC_END      = 9'd5;
    localparam logic [8:0] PAL_VSYNC2_START   = 9'd310;
    localparam logic [8:0] PAL_BLANK_END      = 9'd68;
    localparam logic [8:0] PAL_BLANK2_START   = 9'd269;
    localparam logic [8:0] NTSC_VSYNC_END     = 9'd3;
    localparam logic [8:0] NTSC_ACTIVE_START  = 9'd40;
    localparam logic [8:0] NTSC_ACTIVE_END    = 9'd239;
    localparam logic [8:0] FRAME_START_LINE   = 9'd3;

    // Byte counts per result
    localparam logic [2:0] TEXT_BYTE_COUNT   = 3'd2;
    localparam logic [2:0] BITMAP_BYTE_COUNT = 3'd4;

    // Parameter defaults
    localparam int DEFAULT_BLINK_FRAMES = 16;
    localparam int DEFAULT_BITMAP_LINES = 200;

    localparam int FONT_ADDR_W = 12;
    localparam int FONT_DEPTH  = 4096;

    typedef logic [7:0] byte_t;

    // One font nibble to one pixel byte: each bit becomes 01 (off) or 11 (on)
    function automatic byte_t text_expand(input logic [3:0] nib);
        byte_t r;
        r = 8'h55;
        if (nib[0]) r[1] = 1'b1;
        if (nib[1]) r[3] = 1'b1;
        if (nib[2]) r[5] = 1'b1;
        if (nib[3]) r[7] = 1'b1;
        return r;
    endfunction

    // One bitmap nibble to two pixel bytes: each bit becomes a nibble 5 or F
    function automatic logic [15:0] bitmap_expand(input logic [3:0] nib);
        logic [15:0] r;
        r = 16'h5555;
        if (nib[0]) r[7:4]   = 4'hF;
        if (nib[1]) r[3:0]   = 4'hF;
        if (nib[2]) r[15:12] = 4'hF;
        if (nib[3]) r[11:8]  = 4'hF;
        return r;
    endfunction

endpackage

### src/composite_video_line_sequencer.sv
// Composite video line sequencer.
//
// Input stream (s_*): one item per transfer. s_tuser holds the item kind:
// a line-end tick, a pixel cell (character code or bitmap byte) or a font
// store write. Ticks and pixel cells each give exactly one result on the
// m_* stream; font writes give none. m_tuser tells a line report from a
// pixel result.
// Config port (cfg_*): register index and data, always ready; write only
// while the stream is idle.
//
// Pipeline: stage 1 holds the decoded item beside the registered font
// store read; stage 2 is the output register.
// Throughput: one item per cycle while the receiver does not stall; the
// font store has one write and one read port, used by different items.
//
// Reset (aresetn low, synchronous): both pipeline stages empty, scan line
// 1, bitmap line 0, first buffer shown, cursor visible, registers at their
// defaults. The font store is not cleared.
// When the receiver stalls, the output register holds its result and the
// stage behind it holds too; s_tready drops only once both are full.
module composite_video_line_sequencer
    import cvls_pkg::*;
#(
    parameter int BLINK_FRAMES = DEFAULT_BLINK_FRAMES,  // 1..255
    parameter int BITMAP_LINES = DEFAULT_BITMAP_LINES   // 1..255
) (
    input  logic                   aclk,
    input  logic                   aresetn,

    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [31:0]            s_tdata,   // column[6:0], value[14:7],
                                              // font_address[26:15], zero[31:27]
    input  logic [1:0]             s_tuser,   // mode[1:0]

    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [47:0]            m_tdata,   // line_type[1:0], shown_buffer[2],
                                              // fill_request[3],
                                              // next_bitmap_line[11:4],
                                              // frame_end[12], pixel_data[44:13],
                                              // pixel_byte_count[47:45]
    output logic                   m_tuser,   // item_kind[0]

    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    // ---------------------------------------------------------------
    // Input field unpacking
    // ---------------------------------------------------------------
    logic [1:0]             in_mode;
    logic [6:0]             in_column;
    logic [7:0]             in_value;
    logic [FONT_ADDR_W-1:0] in_font_address;

    assign in_mode         = s_tuser;
    assign in_column       = s_tdata[6:0];
    assign in_value        = s_tdata[14:7];
    assign in_font_address = s_tdata[26:15];

    // ---------------------------------------------------------------
    // Configuration registers
    // ---------------------------------------------------------------
    logic       pal_standard_reg;
    logic       graphics_enable_reg;
    logic       charset_select_reg;
    logic       cursor_enable_reg;
    logic       cursor_blink_enable_reg;
    logic [6:0] cursor_column_reg;
    logic [4:0] cursor_row_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pal_standard_reg        <= 1'b1;
            graphics_enable_reg     <= 1'b0;
            charset_select_reg      <= 1'b0;
            cursor_enable_reg       <= 1'b1;
            cursor_blink_enable_reg <= 1'b1;
            cursor_column_reg       <= 7'd0;
            cursor_row_reg          <= 5'd0;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                CFG_PAL_STANDARD:    pal_standard_reg        <= cfg_data[0];
                CFG_GRAPHICS_ENABLE: graphics_enable_reg     <= cfg_data[0];
                CFG_CHARSET_SELECT:  charset_select_reg      <= cfg_data[0];
                CFG_CURSOR_ENABLE:   cursor_enable_reg       <= cfg_data[0];
                CFG_CURSOR_BLINK:    cursor_blink_enable_reg <= cfg_data[0];
                CFG_CURSOR_COLUMN:   cursor_column_reg       <= cfg_data[6:0];
                CFG_CURSOR_ROW:      cursor_row_reg          <= cfg_data[4:0];
                default: ;  // unknown index: drop the write
            endcase
        end
    end

    // ---------------------------------------------------------------
    // Handshake and pipeline advance
    // ---------------------------------------------------------------
    logic s1_valid_reg;
    logic m_valid_reg;
    logic out_advance;
    logic s1_advance;
    logic s_accept;

    assign out_advance = !m_valid_reg || m_tready;
    assign s1_advance  = !s1_valid_reg || out_advance;
    assign s_tready    = s1_advance;
    assign s_accept    = s_tvalid && s_tready;

    logic is_tick;
    logic is_pixel;
    logic is_font_write;

    assign is_tick       = s_accept && (in_mode == MODE_LINE_TICK);
    assign is_pixel      = s_accept && (in_mode == MODE_PIXEL_CELL);
    assign is_font_write = s_accept && (in_mode == MODE_FONT_WRITE);

    // ---------------------------------------------------------------
    // Frame state
    // ---------------------------------------------------------------
    logic [8:0] scan_line_reg,    scan_line_next;
    logic [7:0] bitmap_line_reg,  bitmap_line_next;
    logic       buffer_phase_reg, buffer_phase_next;
    logic [7:0] blink_frames_reg, blink_frames_next;
    logic       blink_phase_reg,  blink_phase_next;

    logic [1:0] line_type;
    logic       fill_request;
    logic       frame_end;
    logic [8:0] scan_line_inc;
    logic [7:0] blink_frames_inc;

    // Classify the current line with the current standard. Any PAL line
    // outside the sync and border ranges counts as active.
    always_comb begin
        if (pal_standard_reg) begin
            if ((scan_line_reg >= 9'd1 && scan_line_reg <= PAL_VSYNC_END) ||
                (scan_line_reg >= PAL_VSYNC2_START && scan_line_reg <= PAL_LAST_LINE)) begin
                line_type = LINE_VSYNC;
            end else if ((scan_line_reg > PAL_VSYNC_END && scan_line_reg <= PAL_BLANK_END) ||
                         (scan_line_reg >= PAL_BLANK2_START &&
                          scan_line_reg < PAL_VSYNC2_START)) begin
                line_type = LINE_BLANK;
            end else begin
                line_type = LINE_ACTIVE;
            end
        end else begin
            if (scan_line_reg >= 9'd1 && scan_line_reg <= NTSC_VSYNC_END) begin
                line_type = LINE_VSYNC;
            end else if (scan_line_reg >= NTSC_ACTIVE_START &&
                         scan_line_reg <= NTSC_ACTIVE_END) begin
                line_type = LINE_ACTIVE;
            end else begin
                line_type = LINE_BLANK;
            end
        end
    end

    always_comb begin
        bitmap_line_next  = bitmap_line_reg;
        buffer_phase_next = buffer_phase_reg;
        scan_line_next    = scan_line_reg;
        blink_frames_next = blink_frames_reg;
        blink_phase_next  = blink_phase_reg;
        fill_request      = 1'b0;
        frame_end         = 1'b0;
        scan_line_inc     = scan_line_reg + 9'd1;
        blink_frames_inc  = blink_frames_reg + 8'd1;

        // Restart the buffers at the top of the frame; flip them on each
        // active line and ask for the next bitmap line.
        if (scan_line_reg == FRAME_START_LINE) begin
            buffer_phase_next = 1'b0;
            bitmap_line_next  = 8'd0;
            fill_request      = 1'b1;
        end else if (line_type == LINE_ACTIVE) begin
            buffer_phase_next = !buffer_phase_reg;
            bitmap_line_next  = bitmap_line_reg + 8'd1;
            fill_request      = 1'b1;
        end

        scan_line_next = scan_line_inc;
        if (( pal_standard_reg && scan_line_inc > PAL_LAST_LINE) ||
            (!pal_standard_reg && scan_line_inc > NTSC_LAST_LINE)) begin
            scan_line_next    = 9'd1;
            frame_end         = 1'b1;
            blink_frames_next = blink_frames_inc;
            if (blink_frames_inc >= 8'(BLINK_FRAMES)) begin
                blink_frames_next = 8'd0;
                blink_phase_next  = !blink_phase_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            scan_line_reg    <= 9'd1;
            bitmap_line_reg  <= 8'd0;
            buffer_phase_reg <= 1'b0;
            blink_frames_reg <= 8'd0;
            blink_phase_reg  <= 1'b1;
        end else if (is_tick) begin
            scan_line_reg    <= scan_line_next;
            bitmap_line_reg  <= bitmap_line_next;
            buffer_phase_reg <= buffer_phase_next;
            blink_frames_reg <= blink_frames_next;
            blink_phase_reg  <= blink_phase_next;
        end
    end

    // ---------------------------------------------------------------
    // Font store: one write and one registered read per cycle
    // ---------------------------------------------------------------
    byte_t                  font_mem [FONT_DEPTH];
    byte_t                  font_rd_reg;
    logic [FONT_ADDR_W-1:0] font_rd_addr;

    assign font_rd_addr = {charset_select_reg, in_value, bitmap_line_reg[2:0]};

    always_ff @(posedge aclk) begin
        if (is_font_write) begin
            font_mem[in_font_address] <= in_value;
        end
        if (is_pixel) begin
            font_rd_reg <= font_mem[font_rd_addr];
        end
    end

    // ---------------------------------------------------------------
    // Stage 1: hold the decoded item while the font byte is read
    // ---------------------------------------------------------------
    logic       s1_kind_reg;
    logic [1:0] s1_line_type_reg;
    logic       s1_shown_reg;
    logic       s1_fill_reg;
    logic [7:0] s1_next_line_reg;
    logic       s1_frame_end_reg;
    logic       s1_bitmap_reg;
    logic       s1_invert_reg;
    logic [7:0] s1_value_reg;

    logic use_bitmap;
    logic cursor_hit;

    assign use_bitmap = graphics_enable_reg && (bitmap_line_reg < 8'(BITMAP_LINES));
    assign cursor_hit = cursor_enable_reg && !graphics_enable_reg &&
                        (in_column == cursor_column_reg) &&
                        (bitmap_line_reg[7:3] == cursor_row_reg) &&
                        (!cursor_blink_enable_reg || blink_phase_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (s1_advance) begin
            s1_valid_reg <= is_tick || is_pixel;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            s1_kind_reg      <= is_pixel ? KIND_PIXEL_BYTES : KIND_LINE_REPORT;
            s1_line_type_reg <= line_type;
            s1_shown_reg     <= buffer_phase_next;
            s1_fill_reg      <= fill_request;
            s1_next_line_reg <= bitmap_line_next;
            s1_frame_end_reg <= frame_end;
            s1_bitmap_reg    <= use_bitmap;
            s1_invert_reg    <= cursor_hit;
            s1_value_reg     <= in_value;
        end
    end

    // ---------------------------------------------------------------
    // Stage 2: pixel expansion into the output register
    // ---------------------------------------------------------------
    byte_t       font_byte;
    logic [31:0] pixel_data;
    logic [2:0]  pixel_byte_count;

    assign font_byte = font_rd_reg ^ {8{s1_invert_reg}};

    always_comb begin
        if (s1_bitmap_reg) begin
            pixel_data       = {bitmap_expand(s1_value_reg[7:4]),
                                bitmap_expand(s1_value_reg[3:0])};
            pixel_byte_count = BITMAP_BYTE_COUNT;
        end else begin
            // High nibble goes out first
            pixel_data       = {16'd0, text_expand(font_byte[3:0]),
                                text_expand(font_byte[7:4])};
            pixel_byte_count = TEXT_BYTE_COUNT;
        end
    end

    logic        m_kind_reg;
    logic [1:0]  m_line_type_reg;
    logic        m_shown_reg;
    logic        m_fill_reg;
    logic [7:0]  m_next_line_reg;
    logic        m_frame_end_reg;
    logic [31:0] m_pixel_data_reg;
    logic [2:0]  m_byte_count_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_advance) begin
            m_valid_reg <= s1_valid_reg;
        end
    end

    // Zero the fields that do not belong to the result kind
    always_ff @(posedge aclk) begin
        if (out_advance && s1_valid_reg) begin
            m_kind_reg <= s1_kind_reg;
            if (s1_kind_reg == KIND_PIXEL_BYTES) begin
                m_line_type_reg  <= LINE_VSYNC;
                m_shown_reg      <= 1'b0;
                m_fill_reg       <= 1'b0;
                m_next_line_reg  <= 8'd0;
                m_frame_end_reg  <= 1'b0;
                m_pixel_data_reg <= pixel_data;
                m_byte_count_reg <= pixel_byte_count;
            end else begin
                m_line_type_reg  <= s1_line_type_reg;
                m_shown_reg      <= s1_shown_reg;
                m_fill_reg       <= s1_fill_reg;
                m_next_line_reg  <= s1_next_line_reg;
                m_frame_end_reg  <= s1_frame_end_reg;
                m_pixel_data_reg <= 32'd0;
                m_byte_count_reg <= 3'd0;
            end
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_kind_reg;
    assign m_tdata  = {m_byte_count_reg, m_pixel_data_reg, m_frame_end_reg,
                       m_next_line_reg, m_fill_reg, m_shown_reg, m_line_type_reg};

    // ---------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------

    // A pixel result carries two or four bytes
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_kind_reg == KIND_PIXEL_BYTES) |->
            (m_byte_count_reg == TEXT_BYTE_COUNT ||
             m_byte_count_reg == BITMAP_BYTE_COUNT))
        else $error("pixel result with bad byte count");

    // A line report carries no pixel bytes and a valid line class
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_kind_reg == KIND_LINE_REPORT) |->
            (m_pixel_data_reg == 32'd0 && m_byte_count_reg == 3'd0 &&
             m_line_type_reg != 2'd3))
        else $error("line report with pixel fields set");

    // A full stage behind a stalled output register keeps its item
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s1_valid_reg && m_valid_reg && !m_tready) |=> s1_valid_reg)
        else $error("stage 1 item lost under stall");

    // The input side never takes an item while both stages are full and stalled
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s1_valid_reg && m_valid_reg && !m_tready) |-> !s_tready)
        else $error("item accepted into a full pipeline");

endmodule

### verif/tb.sv
`timescale 1ns / 100ps

import cvls_pkg::*;

class video_line_scoreboard;
    typedef struct packed {
        logic        kind;
        logic [1:0]  line_type;
        logic        shown_buffer;
        logic        fill_request;
        logic [7:0]  next_line;
        logic        frame_end;
        logic [31:0] pixels;
        logic [2:0]  byte_count;
    } video_result_t;

    // register copies
    bit            pal_timing;
    bit            graphics_on;
    bit            font_set;
    bit            cursor_enabled;
    bit            cursor_blinks;
    bit [6:0]      cursor_col;
    bit [4:0]      cursor_row;

    // raster state
    bit [8:0]      scan_line;
    bit [7:0]      bitmap_line;
    bit            buffer_phase;
    bit [7:0]      blink_frames;
    bit            blink_visible;
    byte_t         font_rom [FONT_DEPTH];

    video_result_t expected_q[$];

    int mismatches;
    int results_checked;
    int line_reports;
    int active_lines;
    int frame_ends;
    int blink_toggles;
    int bitmap_cells;
    int text_cells;
    int inverted_cells;
    int font_writes;
    int ignored_items;

    function new();
        pal_timing     = 1'b1;
        graphics_on    = 1'b0;
        font_set       = 1'b0;
        cursor_enabled = 1'b1;
        cursor_blinks  = 1'b1;
        cursor_col     = '0;
        cursor_row     = '0;
        scan_line      = 9'd1;
        bitmap_line    = '0;
        buffer_phase   = 1'b0;
        blink_frames   = '0;
        blink_visible  = 1'b1;
    endfunction

    function int pending();
        return expected_q.size();
    endfunction

    function void write_register(logic [CFG_INDEX_W-1:0] index, logic [CFG_DATA_W-1:0] data);
        case (index)
            CFG_PAL_STANDARD:    pal_timing     = data[0];
            CFG_GRAPHICS_ENABLE: graphics_on    = data[0];
            CFG_CHARSET_SELECT:  font_set       = data[0];
            CFG_CURSOR_ENABLE:   cursor_enabled = data[0];
            CFG_CURSOR_BLINK:    cursor_blinks  = data[0];
            CFG_CURSOR_COLUMN:   cursor_col     = data[6:0];
            CFG_CURSOR_ROW:      cursor_row     = data[4:0];
            default: ;
        endcase
    endfunction

    // one font nibble: each bit widens to a pixel pair, 11 lit and 01 dark
    function byte_t shade_byte(logic [3:0] n);
        return {n[3] ? 2'b11 : 2'b01, n[2] ? 2'b11 : 2'b01,
                n[1] ? 2'b11 : 2'b01, n[0] ? 2'b11 : 2'b01};
    endfunction

    // one bitmap nibble: each bit widens to a nibble, F lit and 5 dark
    function logic [15:0] bitmap_word(logic [3:0] n);
        return {n[2] ? 4'hF : 4'h5, n[3] ? 4'hF : 4'h5,
                n[0] ? 4'hF : 4'h5, n[1] ? 4'hF : 4'h5};
    endfunction

    function video_result_t scanline_report();
        video_result_t r;
        logic [8:0]    this_line;
        logic [8:0]    last_line;
        r = '0;
        r.kind = KIND_LINE_REPORT;
        this_line = scan_line;
        if (pal_timing) begin
            if ((this_line >= 1 && this_line <= 5) ||
                (this_line >= 310 && this_line <= 312))
                r.line_type = LINE_VSYNC;
            else if ((this_line >= 6 && this_line <= 68) ||
                     (this_line >= 269 && this_line <= 309))
                r.line_type = LINE_BLANK;
            else
                r.line_type = LINE_ACTIVE;
        end else begin
            if (this_line >= 1 && this_line <= 3)
                r.line_type = LINE_VSYNC;
            else if (this_line >= 40 && this_line <= 239)
                r.line_type = LINE_ACTIVE;
            else
                r.line_type = LINE_BLANK;
        end

        // line 3 restarts the bitmap; active lines swap buffers and move on
        if (this_line == 9'd3) begin
            buffer_phase   = 1'b0;
            bitmap_line    = '0;
            r.fill_request = 1'b1;
        end else if (r.line_type == LINE_ACTIVE) begin
            buffer_phase   = ~buffer_phase;
            bitmap_line    = bitmap_line + 8'd1;
            r.fill_request = 1'b1;
            active_lines++;
        end

        last_line = pal_timing ? 9'd312 : 9'd262;
        scan_line = scan_line + 9'd1;
        if (scan_line > last_line) begin
            scan_line    = 9'd1;
            r.frame_end  = 1'b1;
            blink_frames = blink_frames + 8'd1;
            frame_ends++;
            if (blink_frames >= DEFAULT_BLINK_FRAMES) begin
                blink_frames  = '0;
                blink_visible = ~blink_visible;
                blink_toggles++;
            end
        end
        r.shown_buffer = buffer_phase;
        r.next_line    = bitmap_line;
        line_reports++;
        return r;
    endfunction

    function video_result_t cell_pixels(logic [6:0] column, byte_t code);
        video_result_t r;
        byte_t         glyph;
        r = '0;
        r.kind = KIND_PIXEL_BYTES;
        if (graphics_on && bitmap_line < DEFAULT_BITMAP_LINES) begin
            r.pixels     = {bitmap_word(code[7:4]), bitmap_word(code[3:0])};
            r.byte_count = BITMAP_BYTE_COUNT;
            bitmap_cells++;
        end else begin
            glyph = font_rom[{font_set, code, bitmap_line[2:0]}];
            if (cursor_enabled && !graphics_on && column == cursor_col &&
                bitmap_line[7:3] == cursor_row && (!cursor_blinks || blink_visible)) begin
                glyph = ~glyph;
                inverted_cells++;
            end
            // high nibble goes out first, in the low byte
            r.pixels     = {16'h0000, shade_byte(glyph[3:0]), shade_byte(glyph[7:4])};
            r.byte_count = TEXT_BYTE_COUNT;
            text_cells++;
        end
        return r;
    endfunction

    function void note_input(logic [1:0] mode, logic [6:0] column, byte_t value,
                             logic [FONT_ADDR_W-1:0] addr);
        case (mode)
            MODE_LINE_TICK:  expected_q.push_back(scanline_report());
            MODE_PIXEL_CELL: expected_q.push_back(cell_pixels(column, value));
            MODE_FONT_WRITE: begin
                font_rom[addr] = value;
                font_writes++;
            end
            default: ignored_items++;
        endcase
    endfunction

    function string describe(video_result_t r);
        return $sformatf({"kind=%0d type=%0d shown=%0d fill=%0d line=%0d end=%0d",
                          " pix=%h cnt=%0d"},
                         r.kind, r.line_type, r.shown_buffer, r.fill_request, r.next_line,
                         r.frame_end, r.pixels, r.byte_count);
    endfunction

    function void check_result(logic kind, logic [47:0] data);
        video_result_t got;
        video_result_t want;
        got.kind         = kind;
        got.line_type    = data[1:0];
        got.shown_buffer = data[2];
        got.fill_request = data[3];
        got.next_line    = data[11:4];
        got.frame_end    = data[12];
        got.pixels       = data[44:13];
        got.byte_count   = data[47:45];
        results_checked++;
        if (expected_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
                $display("[%0t] result with nothing outstanding: %s", $time, describe(got));
            return;
        end
        want = expected_q.pop_front();
        if (got !== want) begin
            mismatches++;
            if (mismatches <= 10) begin
                $display("[%0t] result %0d differs", $time, results_checked);
                $display("    expected %s", describe(want));
                $display("    actual   %s", describe(got));
            end
        end
    endfunction
endclass

module tb;
    localparam logic [1:0] MODE_UNUSED  = 2'd3;
    localparam int         DRAIN_CYCLES = 8;
    localparam int         LOADED_CODES = 32;
    // slowest legal run: ~2.1k transfers, each with a full sender gap and
    // receiver stall; allow several times the length of that run
    localparam int         CYCLE_LIMIT  = 2_000_000;

    logic                   aclk      = 1'b0;
    logic                   aresetn   = 1'b0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    logic [31:0]            s_tdata   = '0;
    logic [1:0]             s_tuser   = '0;
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    logic [47:0]            m_tdata;
    logic                   m_tuser;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data  = '0;

    video_line_scoreboard sb;

    int cycles        = 0;
    int sender_burst  = 0;   // transfers left to offer back to back
    int hold_off_left = 0;   // cycles the receiver still has to refuse

    composite_video_line_sequencer dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #10 aclk = ~aclk;

    // Watchdog: end a hung run.
    always @(posedge aclk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycles, sb.pending());
            $display("** composite_video_line_sequencer: FAILED **");
            $finish;
        end
    end

    // Check every result transfer against the oldest prediction.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            sb.check_result(m_tuser, m_tdata);
    end

    // Receiver: runs of ready, short stalls, now and then a long one, and a
    // forced hold-off whenever the stimulus asks for one.
    initial begin
        int ready_run;
        int stall_run;
        int pick;
        ready_run = 0;
        stall_run = 0;
        forever begin
            @(negedge aclk);
            if (ready_run == 0 && stall_run == 0) begin
                ready_run = ($urandom_range(0, 4) == 0) ? $urandom_range(50, 300)
                                                        : $urandom_range(1, 12);
                pick = $urandom_range(0, 99);
                if (pick < 40)      stall_run = 0;
                else if (pick < 80) stall_run = $urandom_range(1, 3);
                else if (pick < 96) stall_run = $urandom_range(4, 15);
                else                stall_run = $urandom_range(30, 100);
            end
            if (hold_off_left > 0) begin
                m_tready = 1'b0;
                hold_off_left--;
            end else if (ready_run > 0) begin
                m_tready = 1'b1;
                ready_run--;
            end else begin
                m_tready = 1'b0;
                stall_run--;
            end
        end
    end

    // Character codes whose glyph rows get loaded: a diagonal and its
    // complement pattern, so every code bit is seen both ways.
    function automatic byte_t loaded_code(input int k);
        logic [4:0] kb;
        kb = 5'(k);
        return {kb[3:0], kb[3:0] ^ {4{kb[4]}}};
    endfunction

    function automatic byte_t pick_code();
        return loaded_code($urandom_range(0, LOADED_CODES - 1));
    endfunction

    // Idle cycles to leave after an input transfer; mostly none or a few.
    function automatic int next_gap();
        int pick;
        if (sender_burst > 0) begin
            sender_burst--;
            return 0;
        end
        pick = $urandom_range(0, 99);
        if (pick < 5) begin
            sender_burst = $urandom_range(20, 120);
            return 0;
        end
        if (pick < 65) return 0;
        if (pick < 90) return $urandom_range(1, 3);
        if (pick < 98) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Offer one item and hold it until the transfer; then maybe drop valid.
    task automatic send_item(input logic [1:0] mode, input logic [6:0] column,
                             input byte_t value, input logic [FONT_ADDR_W-1:0] addr);
        int gap;
        @(negedge aclk);
        s_tvalid = 1'b1;
        s_tuser  = mode;
        s_tdata  = {5'b0, addr, value, column};
        do @(posedge aclk); while (s_tready !== 1'b1);
        sb.note_input(mode, column, value, addr);
        gap = next_gap();
        if (gap > 0) begin
            @(negedge aclk);
            s_tvalid = 1'b0;
            repeat (gap - 1) @(negedge aclk);
        end
    endtask

    // Line tick with junk in the fields it does not use.
    task automatic send_tick();
        send_item(MODE_LINE_TICK, 7'($urandom), 8'($urandom), 12'($urandom));
    endtask

    // Pixel cell, often on the cursor column; sometimes rewrite the very
    // glyph row it reads just before it.
    task automatic send_cell();
        logic [6:0] column;
        byte_t      code;
        column = ($urandom_range(0, 3) == 0) ? sb.cursor_col : 7'($urandom_range(0, 127));
        code   = pick_code();
        if ($urandom_range(0, 11) == 0)
            send_item(MODE_FONT_WRITE, column, 8'($urandom),
                      {sb.font_set, code, sb.bitmap_line[2:0]});
        send_item(MODE_PIXEL_CELL, column, code, 12'($urandom));
    endtask

    // Drop valid, let every outstanding result drain, then settle.
    task automatic wait_idle();
        @(negedge aclk);
        s_tvalid = 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_register(input logic [CFG_INDEX_W-1:0] index,
                                  input logic [CFG_DATA_W-1:0] data);
        @(negedge aclk);
        cfg_valid = 1'b1;
        cfg_index = index;
        cfg_data  = data;
        do @(posedge aclk); while (cfg_ready !== 1'b1);
        sb.write_register(index, data);
        @(negedge aclk);
        cfg_valid = 1'b0;
    endtask

    task automatic apply_settings(input bit pal, input bit gfx, input bit font_set,
                                  input bit cursor_enabled, input bit blinks,
                                  input logic [6:0] col, input logic [4:0] row);
        wait_idle();
        write_register(CFG_PAL_STANDARD,    7'(pal));
        write_register(CFG_GRAPHICS_ENABLE, 7'(gfx));
        write_register(CFG_CHARSET_SELECT,  7'(font_set));
        write_register(CFG_CURSOR_ENABLE,   7'(cursor_enabled));
        write_register(CFG_CURSOR_BLINK,    7'(blinks));
        write_register(CFG_CURSOR_COLUMN,   col);
        write_register(CFG_CURSOR_ROW,      7'(row));
    endtask

    // Mostly well-formed scanlines (tick, then a few cells), with some noise
    // bursts of any item kind in no particular order.
    task automatic run_random_lines(input int budget);
        int         done;
        logic [1:0] mode;
        done = 0;
        while (done < budget) begin
            if ($urandom_range(0, 9) == 0) begin
                repeat ($urandom_range(1, 4)) begin
                    mode = 2'($urandom);
                    send_item(mode, 7'($urandom),
                              (mode == MODE_PIXEL_CELL) ? pick_code() : 8'($urandom),
                              12'($urandom));
                    if (mode != MODE_UNUSED) done++;
                end
            end else begin
                send_tick();
                done++;
                if ($urandom_range(0, 2) != 0) begin
                    repeat ($urandom_range(1, 5)) begin
                        send_cell();
                        done++;
                    end
                end
            end
        end
    endtask

    initial begin : stimulus
        int         phase;
        int         fset;
        int         k;
        int         row;
        logic [6:0] col;

        sb = new();

        // hold reset at the start, then release it once
        repeat (9) @(negedge aclk);
        aresetn = 1'b1;

        // load every glyph row of the codes that cells use, in both fonts
        for (fset = 0; fset < 2; fset++)
            for (k = 0; k < LOADED_CODES; k++)
                for (row = 0; row < 8; row++)
                    send_item(MODE_FONT_WRITE, 7'($urandom), 8'($urandom),
                              {1'(fset), loaded_code(k), 3'(row)});

        // Directed: reset settings, scan line 1, bitmap line 0, cursor at 0,0
        send_item(MODE_PIXEL_CELL, 7'd0,   8'h00, 12'h000);  // cursor cell, inverted
        send_item(MODE_PIXEL_CELL, 7'd0,   8'hFF, 12'hFFF);
        send_item(MODE_PIXEL_CELL, 7'd127, 8'hA5, 12'h000);  // past the text columns
        send_item(MODE_PIXEL_CELL, 7'd80,  8'h5A, 12'h000);
        send_item(MODE_FONT_WRITE, 7'd0,   8'hFF, 12'h000);
        send_item(MODE_PIXEL_CELL, 7'd1,   8'h00, 12'h000);  // reads the row just written
        send_item(MODE_FONT_WRITE, 7'd127, 8'h81, 12'hFFF);
        send_item(MODE_UNUSED,     7'd127, 8'hFF, 12'hFFF);  // must vanish
        repeat (3) send_tick();                              // two vsync, then frame start

        // bitmap mode with every register at its top value
        apply_settings(1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 7'd127, 5'd31);
        send_item(MODE_PIXEL_CELL, 7'd127, 8'h00, 12'h000);
        send_item(MODE_PIXEL_CELL, 7'd127, 8'hFF, 12'h000);
        send_item(MODE_PIXEL_CELL, 7'd0,   8'h0F, 12'h000);
        send_item(MODE_PIXEL_CELL, 7'd0,   8'hF0, 12'h000);

        // NTSC text, second font, steady cursor
        apply_settings(1'b0, 1'b0, 1'b1, 1'b1, 1'b0, 7'd3, 5'd0);
        send_item(MODE_PIXEL_CELL, 7'd3, 8'hFF, 12'h000);
        send_item(MODE_PIXEL_CELL, 7'd4, 8'hFF, 12'h000);
        repeat (2) send_tick();

        // Random phases: bottom and top settings first, then random ones.
        for (phase = 0; phase < 8; phase++) begin
            case (phase)
                0: apply_settings(1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 7'd0, 5'd0);
                1: apply_settings(1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 7'd127, 5'd31);
                default:
                    apply_settings(1'($urandom), 1'($urandom), 1'($urandom), 1'($urandom),
                                   1'($urandom), 7'($urandom), 5'($urandom_range(0, 25)));
            endcase
            if (phase == 4) begin
                // starve the output for a long stretch while input keeps coming
                @(posedge aclk);
                hold_off_left = 400;
                sender_burst  = 300;
            end
            run_random_lines(100);
        end

        // Bitmap through a PAL frame into the bottom border, where the bitmap
        // runs out, then switch to NTSC with the counter past its last line.
        apply_settings(1'b1, 1'b1, 1'b0, 1'b1, 1'b1, 7'($urandom_range(0, 79)), 5'd0);
        while (sb.scan_line != 9'd290) begin
            send_tick();
            if (sb.scan_line[2:0] == 3'd0)
                send_cell();
        end
        apply_settings(1'b0, 1'b1, 1'b0, 1'b1, 1'b1, sb.cursor_col, 5'd0);
        repeat (4) begin
            send_tick();
            send_cell();
        end

        // Cursor row sweep: NTSC text through one whole frame, probing the
        // cursor column on every line of the cursor row.
        col = 7'($urandom_range(0, 127));
        apply_settings(1'b0, 1'b0, 1'($urandom), 1'b1, 1'($urandom), col,
                       5'($urandom_range(1, 24)));
        repeat (262) begin
            send_tick();
            if (sb.bitmap_line[7:3] == sb.cursor_row)
                send_item(MODE_PIXEL_CELL, sb.cursor_col, pick_code(), 12'($urandom));
            else if ($urandom_range(0, 15) == 0)
                send_cell();
        end

        // drain and let the pipeline settle
        wait_idle();

        $display("Run covered %0d line reports (%0d active, %0d frame ends, %0d blink flips),",
                 sb.line_reports, sb.active_lines, sb.frame_ends, sb.blink_toggles);
        $display("%0d text cells (%0d under the cursor), %0d bitmap cells,",
                 sb.text_cells, sb.inverted_cells, sb.bitmap_cells);
        $display("%0d font writes and %0d ignored items.", sb.font_writes, sb.ignored_items);
        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("** composite_video_line_sequencer: PASSED **");
        end else begin
            $display("%0d mismatches, %0d results never arrived", sb.mismatches, sb.pending());
            $display("** composite_video_line_sequencer: FAILED **");
        end
        $finish;
    end
endmodule
